// ===== rtl/core/dbq_pkg.sv =====
// types and codes shared by the double-ended queue
package dbq_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OCC_W  = 9;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT  = 3'd0,
        CMD_PUSH_BACK   = 3'd1,
        CMD_POP_FRONT   = 3'd2,
        CMD_POP_BACK    = 3'd3,
        CMD_CLEAR       = 3'd4,
        CMD_CHECK_FRONT = 3'd5,
        CMD_CHECK_BACK  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FAIL        = 2'd1,
        ST_FULL        = 2'd2,
        ST_CLEAR_EMPTY = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_FILL = 1'b1
    } t_state;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [WORD_W-1:0] value;
    } t_request;

    typedef struct packed {
        t_status                  status;
        logic signed [WORD_W-1:0] front_word;
        logic signed [WORD_W-1:0] back_word;
        logic [OCC_W-1:0]         occupancy;
        logic                     is_empty;
    } t_result;

endpackage

// ===== rtl/core/double_ended_queue.sv =====
// bounded double-ended queue of signed words held in a ring buffer memory
//
// usage: drive i_request and raise start; the request is taken at a rising
// edge where start is high and busy is low. every request gives exactly one
// result on o_result, marked by o_done for a single cycle; the receiver
// cannot stall it and must take it in that cycle.
// results: o_done rises in the cycle after the request is taken; a pop that
// leaves at least one word passes through S_FILL before o_done, since the new end
// word has to come out of the slot memory (one synchronous read port).
// throughput: one request per cycle, except such pops, which hold busy
// high while the queue is in S_FILL.
// front and back words are kept in registers; the memory is written on
// pushes and read only to refill an end register after a pop.
// reset: the queue becomes empty (indices and count zero); slot contents
// are not cleared and no clearing pass is needed.
module double_ended_queue #(
    parameter int unsigned CAPACITY = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  dbq_pkg::t_request i_request,
    output logic              o_done,
    output dbq_pkg::t_result  o_result
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);
    localparam int unsigned WW = dbq_pkg::WORD_W;

    logic signed [WW-1:0] r_mem [CAPACITY];
    logic signed [WW-1:0] r_rd_data;

    dbq_pkg::t_state      r_state, n_state;
    logic [AW-1:0]        r_front_idx, n_front_idx;
    logic [AW-1:0]        r_back_idx, n_back_idx;
    logic [CW-1:0]        r_count, n_count;
    logic signed [WW-1:0] r_front_word, n_front_word;
    logic signed [WW-1:0] r_back_word, n_back_word;
    dbq_pkg::t_status     r_status, n_status;
    logic                 r_done, n_done;
    logic                 r_fill_front, n_fill_front;

    logic                 mem_we;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic                 accept;
    logic                 is_full;
    logic                 is_zero;
    logic [AW-1:0]        front_next, front_prev, back_prev, back_prev2;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - AW'(1);
    endfunction

    assign accept     = start && !busy;
    assign busy       = (r_state != dbq_pkg::S_IDLE);
    assign is_full    = (r_count >= FULL_CNT);
    assign is_zero    = (r_count == '0);
    assign front_next = ring_next(r_front_idx);
    assign front_prev = ring_prev(r_front_idx);
    assign back_prev  = ring_prev(r_back_idx);
    assign back_prev2 = ring_prev(back_prev);

    always_comb begin
        n_state      = r_state;
        n_front_idx  = r_front_idx;
        n_back_idx   = r_back_idx;
        n_count      = r_count;
        n_front_word = r_front_word;
        n_back_word  = r_back_word;
        n_status     = r_status;
        n_done       = 1'b0;
        n_fill_front = r_fill_front;
        mem_we       = 1'b0;
        wr_addr      = r_back_idx;
        rd_addr      = front_next;
        case (r_state)
            dbq_pkg::S_IDLE: begin
                if (accept) begin
                    n_done   = 1'b1;
                    n_status = dbq_pkg::ST_FAIL;
                    case (i_request.command)
                        dbq_pkg::CMD_PUSH_FRONT: begin
                            if (is_full) begin
                                n_status = dbq_pkg::ST_FULL;
                            end else begin
                                n_status     = dbq_pkg::ST_OK;
                                mem_we       = 1'b1;
                                wr_addr      = front_prev;
                                n_front_idx  = front_prev;
                                n_count      = r_count + CW'(1);
                                n_front_word = i_request.value;
                                if (is_zero) begin
                                    n_back_word = i_request.value;
                                end
                            end
                        end
                        dbq_pkg::CMD_PUSH_BACK: begin
                            if (is_full) begin
                                n_status = dbq_pkg::ST_FULL;
                            end else begin
                                n_status    = dbq_pkg::ST_OK;
                                mem_we      = 1'b1;
                                wr_addr     = r_back_idx;
                                n_back_idx  = ring_next(r_back_idx);
                                n_count     = r_count + CW'(1);
                                n_back_word = i_request.value;
                                if (is_zero) begin
                                    n_front_word = i_request.value;
                                end
                            end
                        end
                        dbq_pkg::CMD_POP_FRONT: begin
                            if (!is_zero) begin
                                n_status    = dbq_pkg::ST_OK;
                                n_front_idx = front_next;
                                n_count     = r_count - CW'(1);
                                rd_addr     = front_next;
                                if (r_count == CW'(1)) begin
                                    n_front_word = '0;
                                    n_back_word  = '0;
                                end else begin
                                    n_done       = 1'b0;
                                    n_fill_front = 1'b1;
                                    n_state      = dbq_pkg::S_FILL;
                                end
                            end
                        end
                        dbq_pkg::CMD_POP_BACK: begin
                            if (!is_zero) begin
                                n_status   = dbq_pkg::ST_OK;
                                n_back_idx = back_prev;
                                n_count    = r_count - CW'(1);
                                rd_addr    = back_prev2;
                                if (r_count == CW'(1)) begin
                                    n_front_word = '0;
                                    n_back_word  = '0;
                                end else begin
                                    n_done       = 1'b0;
                                    n_fill_front = 1'b0;
                                    n_state      = dbq_pkg::S_FILL;
                                end
                            end
                        end
                        dbq_pkg::CMD_CLEAR: begin
                            if (is_zero) begin
                                n_status = dbq_pkg::ST_CLEAR_EMPTY;
                            end else begin
                                n_status     = dbq_pkg::ST_OK;
                                n_front_idx  = '0;
                                n_back_idx   = '0;
                                n_count      = '0;
                                n_front_word = '0;
                                n_back_word  = '0;
                            end
                        end
                        dbq_pkg::CMD_CHECK_FRONT: begin
                            if (!is_zero && r_front_word == i_request.value) begin
                                n_status = dbq_pkg::ST_OK;
                            end
                        end
                        dbq_pkg::CMD_CHECK_BACK: begin
                            if (!is_zero && r_back_word == i_request.value) begin
                                n_status = dbq_pkg::ST_OK;
                            end
                        end
                        default: begin
                            n_status = dbq_pkg::ST_FAIL;
                        end
                    endcase
                end
            end
            dbq_pkg::S_FILL: begin
                n_done  = 1'b1;
                n_state = dbq_pkg::S_IDLE;
                if (r_fill_front) begin
                    n_front_word = r_rd_data;
                end else begin
                    n_back_word = r_rd_data;
                end
            end
            default: begin
                n_state = dbq_pkg::S_IDLE;
            end
        endcase
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_request.value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dbq_pkg::S_IDLE;
            r_front_idx  <= '0;
            r_back_idx   <= '0;
            r_count      <= '0;
            r_front_word <= '0;
            r_back_word  <= '0;
            r_status     <= dbq_pkg::ST_OK;
            r_done       <= 1'b0;
            r_fill_front <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_front_idx  <= n_front_idx;
            r_back_idx   <= n_back_idx;
            r_count      <= n_count;
            r_front_word <= n_front_word;
            r_back_word  <= n_back_word;
            r_status     <= n_status;
            r_done       <= n_done;
            r_fill_front <= n_fill_front;
        end
    end

    assign o_done              = r_done;
    assign o_result.status     = r_status;
    assign o_result.front_word = r_front_word;
    assign o_result.back_word  = r_back_word;
    assign o_result.occupancy  = dbq_pkg::OCC_W'(r_count);
    assign o_result.is_empty   = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("occupancy above capacity");

    a_fill_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dbq_pkg::S_FILL |=> r_state == dbq_pkg::S_IDLE && o_done)
        else $error("refill did not finish in one cycle");

    a_request_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done || busy)
        else $error("request neither answered nor in progress");

    a_empty_words_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.is_empty |-> o_result.front_word == '0
            && o_result.back_word == '0)
        else $error("empty queue reports nonzero end words");

endmodule

// ===== tb/tb_double_ended_queue.sv =====
// self-checking testbench for the double-ended queue with a ring-buffer predictor
module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH       = 256;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 10;
    localparam int unsigned ITEM_TARGET = 450;
    localparam logic [2:0]  CMD_UNUSED  = 3'd7;

    typedef struct packed {
        logic              hold;
        dbq_pkg::t_request req;
    } t_pending;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    dbq_pkg::t_request i_request;
    logic              o_done;
    dbq_pkg::t_result  o_result;

    double_ended_queue #(.CAPACITY(DEPTH)) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_request (i_request),
        .o_done    (o_done),
        .o_result  (o_result)
    );

    t_pending                          request_queue[$];
    dbq_pkg::t_result                  pending_results[$];
    logic signed [dbq_pkg::WORD_W-1:0] shadow_words[$];

    logic signed [dbq_pkg::WORD_W-1:0] deque_slots[DEPTH];
    logic [7:0]                        deque_head;
    logic [7:0]                        deque_tail;
    logic [8:0]                        deque_count;

    logic             took_req;
    int               errors;
    int               stall_cycles;
    int               burst_left;
    int               gap_left;
    dbq_pkg::t_result want;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic dbq_pkg::t_result deque_apply(dbq_pkg::t_request req);
        dbq_pkg::t_result r;
        r.status = dbq_pkg::ST_FAIL;
        case (req.command)
            dbq_pkg::CMD_PUSH_FRONT: begin
                if (deque_count >= DEPTH) begin
                    r.status = dbq_pkg::ST_FULL;
                end else begin
                    deque_head = deque_head - 8'd1;
                    deque_slots[deque_head] = req.value;
                    deque_count = deque_count + 9'd1;
                    r.status = dbq_pkg::ST_OK;
                end
            end
            dbq_pkg::CMD_PUSH_BACK: begin
                if (deque_count >= DEPTH) begin
                    r.status = dbq_pkg::ST_FULL;
                end else begin
                    deque_slots[deque_tail] = req.value;
                    deque_tail = deque_tail + 8'd1;
                    deque_count = deque_count + 9'd1;
                    r.status = dbq_pkg::ST_OK;
                end
            end
            dbq_pkg::CMD_POP_FRONT: begin
                if (deque_count != 0) begin
                    deque_head = deque_head + 8'd1;
                    deque_count = deque_count - 9'd1;
                    r.status = dbq_pkg::ST_OK;
                end
            end
            dbq_pkg::CMD_POP_BACK: begin
                if (deque_count != 0) begin
                    deque_tail = deque_tail - 8'd1;
                    deque_count = deque_count - 9'd1;
                    r.status = dbq_pkg::ST_OK;
                end
            end
            dbq_pkg::CMD_CLEAR: begin
                if (deque_count == 0) begin
                    r.status = dbq_pkg::ST_CLEAR_EMPTY;
                end else begin
                    deque_head = '0;
                    deque_tail = '0;
                    deque_count = '0;
                    r.status = dbq_pkg::ST_OK;
                end
            end
            dbq_pkg::CMD_CHECK_FRONT: begin
                if (deque_count != 0 && deque_slots[deque_head] == req.value) begin
                    r.status = dbq_pkg::ST_OK;
                end
            end
            dbq_pkg::CMD_CHECK_BACK: begin
                if (deque_count != 0 && deque_slots[deque_tail - 8'd1] == req.value) begin
                    r.status = dbq_pkg::ST_OK;
                end
            end
            default: begin
            end
        endcase
        r.front_word = (deque_count != 0) ? deque_slots[deque_head] : '0;
        r.back_word  = (deque_count != 0) ? deque_slots[deque_tail - 8'd1] : '0;
        r.occupancy  = deque_count;
        r.is_empty   = (deque_count == 0);
        return r;
    endfunction

    function automatic logic signed [dbq_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return -32'sd1;
            2: return 32'sh8000_0000;
            3: return 32'sh7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // check value: the end word itself half the time, else a near miss or random word
    function automatic logic signed [dbq_pkg::WORD_W-1:0] pick_check(bit at_back);
        logic signed [dbq_pkg::WORD_W-1:0] w;
        if (shadow_words.size() == 0) return pick_word();
        w = at_back ? shadow_words[shadow_words.size() - 1] : shadow_words[0];
        case ($urandom_range(0, 3))
            0, 1: return w;
            2: return w ^ (32'sd1 << $urandom_range(0, 31));
            default: return pick_word();
        endcase
    endfunction

    task automatic queue_request(logic [2:0] cmd,
                                 logic signed [dbq_pkg::WORD_W-1:0] val, bit hold);
        t_pending p;
        case (cmd)
            dbq_pkg::CMD_PUSH_FRONT:
                if (shadow_words.size() < DEPTH) shadow_words.push_front(val);
            dbq_pkg::CMD_PUSH_BACK:
                if (shadow_words.size() < DEPTH) shadow_words.push_back(val);
            dbq_pkg::CMD_POP_FRONT:
                if (shadow_words.size() != 0) shadow_words.pop_front();
            dbq_pkg::CMD_POP_BACK:
                if (shadow_words.size() != 0) shadow_words.pop_back();
            dbq_pkg::CMD_CLEAR:
                shadow_words.delete();
            default: begin
            end
        endcase
        p.hold = hold;
        p.req.command = cmd;
        p.req.value = val;
        request_queue.push_back(p);
    endtask

    task automatic queue_random_request(bit hold);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)      queue_request(dbq_pkg::CMD_PUSH_FRONT, pick_word(), hold);
        else if (pick < 42) queue_request(dbq_pkg::CMD_PUSH_BACK, pick_word(), hold);
        else if (pick < 56) queue_request(dbq_pkg::CMD_POP_FRONT, pick_word(), hold);
        else if (pick < 70) queue_request(dbq_pkg::CMD_POP_BACK, pick_word(), hold);
        else if (pick < 80) queue_request(dbq_pkg::CMD_CHECK_FRONT, pick_check(1'b0), hold);
        else if (pick < 90) queue_request(dbq_pkg::CMD_CHECK_BACK, pick_check(1'b1), hold);
        else if (pick < 95) queue_request(dbq_pkg::CMD_CLEAR, pick_word(), hold);
        else                queue_request(CMD_UNUSED, pick_word(), hold);
    endtask

    task automatic note_error(string msg);
        if (errors < 10) $display("%s", msg);
        errors++;
    endtask

    task automatic check_field(string name, logic [dbq_pkg::WORD_W-1:0] exp_val,
                               logic [dbq_pkg::WORD_W-1:0] got_val);
        if (exp_val !== got_val) begin
            note_error($sformatf("mismatch in %s at %0t: expected %0h, got %0h",
                                 name, $time, exp_val, got_val));
        end
    endtask

    // driver: requests change on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (took_req) request_queue.pop_front();
            if (gap_left != 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (request_queue.size() == 0) begin
                start <= 1'b0;
            end else if (request_queue[0].hold && pending_results.size() != 0) begin
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                i_request <= request_queue[0].req;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // monitor: requests and results are taken on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            took_req <= 1'b0;
        end else begin
            took_req <= start && !busy;
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    note_error($sformatf("result with no request outstanding at %0t", $time));
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(o_result.status));
                    check_field("front_word", want.front_word, o_result.front_word);
                    check_field("back_word", want.back_word, o_result.back_word);
                    check_field("occupancy", 32'(want.occupancy), 32'(o_result.occupancy));
                    check_field("is_empty", 32'(want.is_empty), 32'(o_result.is_empty));
                end
            end
            if (start && !busy) pending_results.push_back(deque_apply(i_request));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        bit filled;
        int seg_len;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_request = '0;
        errors = 0;
        burst_left = 0;
        gap_left = 0;
        filled = 1'b0;
        deque_head = '0;
        deque_tail = '0;
        deque_count = '0;

        // empty queue cases
        queue_request(dbq_pkg::CMD_POP_FRONT, 32'sd0, 1'b0);
        queue_request(dbq_pkg::CMD_POP_BACK, 32'sd0, 1'b0);
        queue_request(dbq_pkg::CMD_CHECK_FRONT, 32'sd0, 1'b0);
        queue_request(dbq_pkg::CMD_CHECK_BACK, -32'sd1, 1'b0);
        queue_request(dbq_pkg::CMD_CLEAR, 32'sd0, 1'b0);
        queue_request(CMD_UNUSED, 32'sh7fff_ffff, 1'b0);
        // extreme words at both ends
        queue_request(dbq_pkg::CMD_PUSH_FRONT, 32'sh7fff_ffff, 1'b0);
        queue_request(dbq_pkg::CMD_PUSH_BACK, 32'sh8000_0000, 1'b0);
        queue_request(dbq_pkg::CMD_PUSH_FRONT, -32'sd1, 1'b0);
        queue_request(dbq_pkg::CMD_PUSH_BACK, 32'sd0, 1'b0);
        queue_request(dbq_pkg::CMD_CHECK_FRONT, -32'sd1, 1'b0);
        queue_request(dbq_pkg::CMD_CHECK_BACK, 32'sd0, 1'b0);
        queue_request(dbq_pkg::CMD_CHECK_FRONT, 32'sd0, 1'b0);
        queue_request(dbq_pkg::CMD_CHECK_BACK, 32'sd1, 1'b0);
        queue_request(dbq_pkg::CMD_POP_FRONT, 32'sd0, 1'b0);
        queue_request(dbq_pkg::CMD_POP_BACK, 32'sd0, 1'b0);
        queue_request(CMD_UNUSED, 32'sh8000_0000, 1'b0);
        queue_request(dbq_pkg::CMD_POP_BACK, 32'sd0, 1'b0);
        queue_request(dbq_pkg::CMD_POP_FRONT, 32'sd0, 1'b0);
        queue_request(dbq_pkg::CMD_PUSH_BACK, 32'sd5, 1'b0);
        queue_request(dbq_pkg::CMD_CLEAR, 32'sd0, 1'b0);
        queue_request(dbq_pkg::CMD_PUSH_FRONT, 32'sd123, 1'b0);
        queue_request(dbq_pkg::CMD_POP_BACK, 32'sd0, 1'b0);

        while (request_queue.size() < ITEM_TARGET) begin
            if (!filled && request_queue.size() > 150) begin
                // fill to capacity, push past it, then work the full queue
                filled = 1'b1;
                queue_request(dbq_pkg::CMD_PUSH_BACK, pick_word(), 1'b1);
                while (shadow_words.size() < DEPTH) begin
                    queue_request($urandom_range(0, 1) ? dbq_pkg::CMD_PUSH_FRONT
                                                       : dbq_pkg::CMD_PUSH_BACK,
                                  pick_word(), 1'b0);
                end
                queue_request(dbq_pkg::CMD_PUSH_FRONT, pick_word(), 1'b0);
                queue_request(dbq_pkg::CMD_PUSH_BACK, pick_word(), 1'b0);
                queue_request(dbq_pkg::CMD_CHECK_FRONT, pick_check(1'b0), 1'b0);
                queue_request(dbq_pkg::CMD_CHECK_BACK, pick_check(1'b1), 1'b0);
                queue_request(dbq_pkg::CMD_POP_FRONT, pick_word(), 1'b0);
                queue_request(dbq_pkg::CMD_POP_BACK, pick_word(), 1'b0);
                queue_request(dbq_pkg::CMD_PUSH_FRONT, pick_word(), 1'b0);
                queue_request(dbq_pkg::CMD_PUSH_BACK, pick_word(), 1'b0);
                queue_request(dbq_pkg::CMD_PUSH_BACK, pick_word(), 1'b0);
                queue_request(dbq_pkg::CMD_CLEAR, pick_word(), 1'b0);
            end else begin
                seg_len = $urandom_range(5, 40);
                queue_random_request($urandom_range(0, 3) == 0);
                repeat (seg_len - 1) queue_random_request(1'b0);
            end
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() != 0 || pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dbq_pkg.sv
rtl/core/double_ended_queue.sv
tb/tb_double_ended_queue.sv
